### hw/rtl/complex_number_alu_macros.svh
// Assertion macros shared by the complex number ALU RTL.
// Depends on signals named clk and rst_n in the including module.
`ifndef COMPLEX_NUMBER_ALU_MACROS_SVH
`define COMPLEX_NUMBER_ALU_MACROS_SVH

// Combinational property checked at every clock edge outside reset.
`define CNA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication with the consequent checked in the same cycle.
`define CNA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/cna_pkg.sv
// Package for the complex number ALU: operation and status codes, stage payload types
// and saturation helpers. No dependencies.
package cna_pkg;

    // Default number of fraction bits of the fixed-point operands.
    localparam int FRAC_BITS_DEF = 16;

    // Quotient bits produced by the divider; one pipeline stage per bit.
    localparam int DIV_STEPS = 33;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_EQ   = 3'd4,
        OP_CONJ = 3'd5,
        OP_MAG  = 3'd6,
        OP_NZ   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // Registered operands.
    typedef struct packed {
        op_t                op;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } in_t;

    // Partial products plus the finished results of the simple operations.
    typedef struct packed {
        op_t                op;
        logic signed [63:0] pp0;
        logic signed [63:0] pp1;
        logic signed [63:0] pp2;
        logic signed [63:0] pp3;
        logic signed [63:0] pp4;
        logic signed [63:0] pp5;
        logic signed [31:0] rr;
        logic signed [31:0] ri;
        logic               flag;
        status_t            st;
    } prod_t;

    // Exact sums of product pairs and the divisor's squared magnitude.
    typedef struct packed {
        op_t                op;
        logic signed [64:0] sa;
        logic signed [64:0] sb;
        logic [63:0]        den;
        logic signed [31:0] rr;
        logic signed [31:0] ri;
        logic               flag;
        status_t            st;
    } sum_t;

    // Divider state for both parts, plus finished results for everything else.
    typedef struct packed {
        logic               is_div;
        logic signed [31:0] rr;
        logic signed [31:0] ri;
        logic               flag;
        status_t            st;
        logic [63:0]        den;
        logic [63:0]        mag_re;
        logic [63:0]        mag_im;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        logic [63:0]        rem_re;
        logic [63:0]        rem_im;
        logic [32:0]        q_re;
        logic [32:0]        q_im;
    } div_t;

    // True when a 33-bit signed value does not fit 32 bits.
    function automatic logic ovf_s33(input logic [32:0] v);
        return v[32] != v[31];
    endfunction

    function automatic logic [31:0] sat_s33(input logic [32:0] v);
        if (ovf_s33(v))
        begin
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // True when a 65-bit signed value does not fit 32 bits.
    function automatic logic ovf_s65(input logic [64:0] v);
        return (|v[64:31]) && !(&v[64:31]);
    endfunction

    function automatic logic [31:0] sat_s65(input logic [64:0] v);
        if (ovf_s65(v))
        begin
            return v[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

endpackage

### hw/rtl/cna_if.sv
// Valid/ready stream interfaces for the complex number ALU request and response.
// No dependencies.
interface cna_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] a_real;
    logic [31:0] a_imag;
    logic [31:0] b_real;
    logic [31:0] b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cna_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] res_real;
    logic [31:0] res_imag;
    logic        flag;
    logic [1:0]  status;

    modport source (output valid, res_real, res_imag, flag, status, input ready);
    modport sink   (input valid, res_real, res_imag, flag, status, output ready);
endinterface

### hw/rtl/cna_mul_stage.sv
// First two pipeline stages: operand register, then six 32x32 products and the
// results of add, subtract, equal, conjugate and nonzero. Depends on cna_pkg, cna_if.
module cna_mul_stage (
    input  logic            clk,
    input  logic            rst_n,
    cna_req_if.sink         req,
    output logic            down_valid,
    output cna_pkg::prod_t  down_data,
    input  logic            down_ready
);

    logic            v0_reg;
    cna_pkg::in_t    s0_reg;
    logic            v1_reg;
    cna_pkg::prod_t  s1_reg;
    cna_pkg::prod_t  s1_next;
    logic            en0;
    logic            en1;
    logic [32:0]     sum_re;
    logic [32:0]     sum_im;

    // A stage loads when it is empty or its content moves on.
    assign en1       = !v1_reg || down_ready;
    assign en0       = !v0_reg || en1;
    assign req.ready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= req.valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    // Capture the operands of an accepted transaction.
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_reg.op <= cna_pkg::op_t'(req.operation);
            s0_reg.ar <= req.a_real;
            s0_reg.ai <= req.a_imag;
            s0_reg.br <= req.b_real;
            s0_reg.bi <= req.b_imag;
        end
    end

    // Products shared by multiply, divide and squared magnitude, plus simple results.
    always_comb
    begin
        s1_next      = '0;
        s1_next.op   = s0_reg.op;
        s1_next.pp0  = s0_reg.ar * s0_reg.br;
        s1_next.pp1  = s0_reg.ai * s0_reg.bi;
        s1_next.pp2  = s0_reg.ar * s0_reg.bi;
        s1_next.pp3  = s0_reg.ai * s0_reg.br;
        if (s0_reg.op == cna_pkg::OP_MAG)
        begin
            s1_next.pp4 = s0_reg.ar * s0_reg.ar;
            s1_next.pp5 = s0_reg.ai * s0_reg.ai;
        end
        else
        begin
            s1_next.pp4 = s0_reg.br * s0_reg.br;
            s1_next.pp5 = s0_reg.bi * s0_reg.bi;
        end
        sum_re = '0;
        sum_im = '0;
        case (s0_reg.op)
            cna_pkg::OP_ADD:
            begin
                sum_re = {s0_reg.ar[31], s0_reg.ar} + {s0_reg.br[31], s0_reg.br};
                sum_im = {s0_reg.ai[31], s0_reg.ai} + {s0_reg.bi[31], s0_reg.bi};
            end
            cna_pkg::OP_SUB:
            begin
                sum_re = {s0_reg.ar[31], s0_reg.ar} - {s0_reg.br[31], s0_reg.br};
                sum_im = {s0_reg.ai[31], s0_reg.ai} - {s0_reg.bi[31], s0_reg.bi};
            end
            cna_pkg::OP_CONJ:
            begin
                sum_re = {s0_reg.ar[31], s0_reg.ar};
                sum_im = 33'd0 - {s0_reg.ai[31], s0_reg.ai};
            end
            default:
            begin
                sum_re = '0;
                sum_im = '0;
            end
        endcase
        s1_next.rr = cna_pkg::sat_s33(sum_re);
        s1_next.ri = cna_pkg::sat_s33(sum_im);
        s1_next.st = (cna_pkg::ovf_s33(sum_re) || cna_pkg::ovf_s33(sum_im)) ?
                     cna_pkg::ST_SAT : cna_pkg::ST_OK;
        case (s0_reg.op)
            cna_pkg::OP_EQ:
            begin
                s1_next.flag = (s0_reg.ar == s0_reg.br) && (s0_reg.ai == s0_reg.bi);
            end
            cna_pkg::OP_NZ:
            begin
                s1_next.flag = (s0_reg.ar != '0) || (s0_reg.ai != '0);
            end
            default:
            begin
                s1_next.flag = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
    end

    assign down_valid = v1_reg;
    assign down_data  = s1_reg;

endmodule

### hw/rtl/cna_prep.sv
// Two pipeline stages: exact 65-bit sums of product pairs, then scaling and saturation
// for multiply and magnitude, or divider setup for divide. Depends on cna_pkg.
module cna_prep #(
    parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  cna_pkg::prod_t  up_data,
    output logic            up_ready,
    output logic            down_valid,
    output cna_pkg::div_t   down_data,
    input  logic            down_ready
);

    // Dividend bits above the quotient window seed the remainder.
    localparam int RSH = cna_pkg::DIV_STEPS - FRAC_BITS;

    logic               v2_reg;
    cna_pkg::sum_t      s2_reg;
    cna_pkg::sum_t      s2_next;
    logic               v3_reg;
    cna_pkg::div_t      s3_reg;
    cna_pkg::div_t      s3_next;
    logic               en2;
    logic               en3;
    logic signed [64:0] sh_a;
    logic signed [64:0] sh_b;
    logic [64:0]        abs_a;
    logic [64:0]        abs_b;
    logic [63:0]        top_a;
    logic [63:0]        top_b;

    assign en3      = !v3_reg || down_ready;
    assign en2      = !v2_reg || en3;
    assign up_ready = en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= up_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Exact pair sums for each operation.
    always_comb
    begin
        s2_next      = '0;
        s2_next.op   = up_data.op;
        s2_next.rr   = up_data.rr;
        s2_next.ri   = up_data.ri;
        s2_next.flag = up_data.flag;
        s2_next.st   = up_data.st;
        s2_next.den  = 64'(up_data.pp4) + 64'(up_data.pp5);
        case (up_data.op)
            cna_pkg::OP_MUL:
            begin
                s2_next.sa = 65'(up_data.pp0) - 65'(up_data.pp1);
                s2_next.sb = 65'(up_data.pp2) + 65'(up_data.pp3);
            end
            cna_pkg::OP_DIV:
            begin
                s2_next.sa = 65'(up_data.pp0) + 65'(up_data.pp1);
                s2_next.sb = 65'(up_data.pp3) - 65'(up_data.pp2);
            end
            cna_pkg::OP_MAG:
            begin
                s2_next.sa = 65'(up_data.pp4) + 65'(up_data.pp5);
                s2_next.sb = '0;
            end
            default:
            begin
                s2_next.sa = '0;
                s2_next.sb = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_reg <= s2_next;
        end
    end

    // Floor scaling for products, or magnitude, sign and seed remainder for divide.
    always_comb
    begin
        sh_a  = s2_reg.sa >>> FRAC_BITS;
        sh_b  = s2_reg.sb >>> FRAC_BITS;
        abs_a = s2_reg.sa[64] ? (65'd0 - s2_reg.sa) : s2_reg.sa;
        abs_b = s2_reg.sb[64] ? (65'd0 - s2_reg.sb) : s2_reg.sb;
        top_a = abs_a[63:0] >> RSH;
        top_b = abs_b[63:0] >> RSH;

        s3_next        = '0;
        s3_next.rr     = s2_reg.rr;
        s3_next.ri     = s2_reg.ri;
        s3_next.flag   = s2_reg.flag;
        s3_next.st     = s2_reg.st;
        s3_next.den    = s2_reg.den;
        s3_next.mag_re = abs_a[63:0];
        s3_next.mag_im = abs_b[63:0];
        s3_next.neg_re = s2_reg.sa[64];
        s3_next.neg_im = s2_reg.sb[64];
        case (s2_reg.op)
            cna_pkg::OP_MUL, cna_pkg::OP_MAG:
            begin
                s3_next.rr = cna_pkg::sat_s65(sh_a);
                s3_next.ri = cna_pkg::sat_s65(sh_b);
                s3_next.st = (cna_pkg::ovf_s65(sh_a) || cna_pkg::ovf_s65(sh_b)) ?
                             cna_pkg::ST_SAT : cna_pkg::ST_OK;
            end
            cna_pkg::OP_DIV:
            begin
                if (s2_reg.den == '0)
                begin
                    s3_next.rr = '0;
                    s3_next.ri = '0;
                    s3_next.st = cna_pkg::ST_DIVZ;
                end
                else
                begin
                    // A quotient of 2^33 or more is flagged now and saturates later.
                    s3_next.is_div = 1'b1;
                    s3_next.st     = cna_pkg::ST_OK;
                    s3_next.ovf_re = top_a >= s2_reg.den;
                    s3_next.ovf_im = top_b >= s2_reg.den;
                    s3_next.rem_re = (top_a >= s2_reg.den) ? '0 : top_a;
                    s3_next.rem_im = (top_b >= s2_reg.den) ? '0 : top_b;
                end
            end
            default:
            begin
                s3_next.is_div = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign down_valid = v3_reg;
    assign down_data  = s3_reg;

endmodule

### hw/rtl/cna_div_stage.sv
// One restoring division step for both parts of a quotient, as one pipeline stage.
// Depends on cna_pkg.
module cna_div_stage #(
    parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF,
    parameter int STEP      = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    input  cna_pkg::div_t  up_data,
    output logic           up_ready,
    output logic           down_valid,
    output cna_pkg::div_t  down_data,
    input  logic           down_ready
);

    // Dividend bit brought in at this step, counted from the quotient LSB.
    localparam int BITPOS = cna_pkg::DIV_STEPS - 1 - STEP;

    logic           v_reg;
    cna_pkg::div_t  d_reg;
    cna_pkg::div_t  d_next;
    logic           en;
    logic           bit_re;
    logic           bit_im;
    logic [64:0]    r2_re;
    logic [64:0]    r2_im;
    logic [64:0]    den_x;
    logic           ge_re;
    logic           ge_im;
    logic [64:0]    diff_re;
    logic [64:0]    diff_im;

    assign en       = !v_reg || down_ready;
    assign up_ready = en;

    // The dividend is the magnitude shifted up by the fraction bits.
    if (BITPOS >= FRAC_BITS)
    begin : g_mag_bit
        assign bit_re = up_data.mag_re[BITPOS - FRAC_BITS];
        assign bit_im = up_data.mag_im[BITPOS - FRAC_BITS];
    end
    else
    begin : g_zero_bit
        assign bit_re = 1'b0;
        assign bit_im = 1'b0;
    end

    // Shift in one bit, compare with the divisor, subtract when it fits.
    always_comb
    begin
        den_x   = {1'b0, up_data.den};
        r2_re   = {up_data.rem_re, bit_re};
        r2_im   = {up_data.rem_im, bit_im};
        ge_re   = r2_re >= den_x;
        ge_im   = r2_im >= den_x;
        diff_re = r2_re - den_x;
        diff_im = r2_im - den_x;
        d_next        = up_data;
        d_next.rem_re = ge_re ? diff_re[63:0] : r2_re[63:0];
        d_next.rem_im = ge_im ? diff_im[63:0] : r2_im[63:0];
        d_next.q_re   = {up_data.q_re[31:0], ge_re};
        d_next.q_im   = {up_data.q_im[31:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign down_valid = v_reg;
    assign down_data  = d_reg;

endmodule

### hw/rtl/cna_out_stage.sv
// Output register: signs and saturates divide quotients and drives the response channel.
// Depends on cna_pkg, cna_if.
module cna_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    input  cna_pkg::div_t  up_data,
    output logic           up_ready,
    cna_rsp_if.source      rsp
);

    logic              v_reg;
    logic [31:0]       rr_reg;
    logic [31:0]       ri_reg;
    logic              flag_reg;
    cna_pkg::status_t  st_reg;
    logic [31:0]       rr_next;
    logic [31:0]       ri_next;
    logic              flag_next;
    cna_pkg::status_t  st_next;
    logic              en;
    logic              sat_re;
    logic              sat_im;
    logic [32:0]       neg_q_re;
    logic [32:0]       neg_q_im;

    assign en       = !v_reg || rsp.ready;
    assign up_ready = en;

    // A negative quotient may reach 2^31, a positive one only 2^31 - 1.
    always_comb
    begin
        sat_re   = up_data.ovf_re || (up_data.neg_re ? (up_data.q_re > 33'h0_8000_0000)
                                                     : (up_data.q_re > 33'h0_7FFF_FFFF));
        sat_im   = up_data.ovf_im || (up_data.neg_im ? (up_data.q_im > 33'h0_8000_0000)
                                                     : (up_data.q_im > 33'h0_7FFF_FFFF));
        neg_q_re = 33'd0 - up_data.q_re;
        neg_q_im = 33'd0 - up_data.q_im;
        if (up_data.is_div)
        begin
            if (sat_re)
            begin
                rr_next = up_data.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                rr_next = up_data.neg_re ? neg_q_re[31:0] : up_data.q_re[31:0];
            end
            if (sat_im)
            begin
                ri_next = up_data.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                ri_next = up_data.neg_im ? neg_q_im[31:0] : up_data.q_im[31:0];
            end
            flag_next = 1'b0;
            st_next   = (sat_re || sat_im) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
        end
        else
        begin
            rr_next   = up_data.rr;
            ri_next   = up_data.ri;
            flag_next = up_data.flag;
            st_next   = up_data.st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg   <= rr_next;
            ri_reg   <= ri_next;
            flag_reg <= flag_next;
            st_reg   <= st_next;
        end
    end

    assign rsp.valid    = v_reg;
    assign rsp.res_real = rr_reg;
    assign rsp.res_imag = ri_reg;
    assign rsp.flag     = flag_reg;
    assign rsp.status   = st_reg;

endmodule

### hw/rtl/complex_number_alu.sv
// Complex number ALU on signed fixed-point operands (FRAC_BITS fraction bits, Q16.16 by
// default): add, subtract, multiply, divide, equal, conjugate, squared magnitude and
// nonzero test, with saturation and a divide-by-zero status. It is a fully pipelined
// unit that accepts one transaction per clock while the response side does not stall
// and returns results in order through 38 register stages: two stages for the operand
// register and the 32x32 products, two for the exact sums and scaling or divider setup,
// one stage per quotient bit of the 33-step restoring divider, and the output register.
// Every stage holds its content under back-pressure and fills empty slots, so new
// transactions are taken while a finished result waits. Depends on cna_pkg, cna_if and
// the stage modules.
`include "complex_number_alu_macros.svh"

module complex_number_alu #(
    parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cna_req_if.sink    req,
    cna_rsp_if.source  rsp
);

    localparam int NSTEP = cna_pkg::DIV_STEPS;

    logic            prod_valid;
    cna_pkg::prod_t  prod_data;
    logic            prod_ready;
    logic            div_valid [NSTEP + 1];
    cna_pkg::div_t   div_data  [NSTEP + 1];
    logic            div_ready [NSTEP + 1];

    // Operand register and products.
    cna_mul_stage u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .down_valid (prod_valid),
        .down_data  (prod_data),
        .down_ready (prod_ready)
    );

    // Sums, scaling and divider setup.
    cna_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (prod_valid),
        .up_data    (prod_data),
        .up_ready   (prod_ready),
        .down_valid (div_valid[0]),
        .down_data  (div_data[0]),
        .down_ready (div_ready[0])
    );

    // Divider pipeline, one quotient bit per stage.
    for (genvar k = 0; k < NSTEP; k++)
    begin : g_div
        cna_div_stage #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (k)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (div_valid[k]),
            .up_data    (div_data[k]),
            .up_ready   (div_ready[k]),
            .down_valid (div_valid[k + 1]),
            .down_data  (div_data[k + 1]),
            .down_ready (div_ready[k + 1])
        );
    end

    // Final selection and response register.
    cna_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (div_valid[NSTEP]),
        .up_data  (div_data[NSTEP]),
        .up_ready (div_ready[NSTEP]),
        .rsp      (rsp)
    );

    // Result consistency checks.
    `CNA_ASSERT_IMPLY(a_divz_zero, rsp.valid && (rsp.status == cna_pkg::ST_DIVZ), (rsp.res_real == '0) && (rsp.res_imag == '0) && !rsp.flag, "divide by zero must give zero results")
    `CNA_ASSERT_IMPLY(a_flag_ok, rsp.valid && rsp.flag, rsp.status == cna_pkg::ST_OK, "flag set with nonzero status")
    `CNA_ASSERT_IMPLY(a_status_code, rsp.valid, (rsp.status == cna_pkg::ST_OK) || (rsp.status == cna_pkg::ST_SAT) || (rsp.status == cna_pkg::ST_DIVZ), "undefined status code")

endmodule
